FILE: design/hilbert_turtle_command_generator_unit_macros.svh
// ----------------------------------------------------------------------------
// Hilbert turtle command generator - assertion macros
// Shorthand for clocked checks on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef HILBERT_TURTLE_COMMAND_GENERATOR_UNIT_MACROS_SVH
`define HILBERT_TURTLE_COMMAND_GENERATOR_UNIT_MACROS_SVH

// same-cycle implication
`define HTCG_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HTCG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/htcg_pkg.sv
// ----------------------------------------------------------------------------
// htcg_pkg
// Shared constants and types of the Hilbert turtle command generator.
// ----------------------------------------------------------------------------
`default_nettype none

package htcg_pkg;

  localparam int unsigned MAX_ORDER = 8;
  localparam int unsigned LVL_W     = $clog2(MAX_ORDER + 1);
  localparam int unsigned IDX_W     = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int unsigned ORDER_W   = 4;
  localparam int unsigned POS_W     = 4;

  typedef enum logic [1:0] {
    CMD_RIGHT = 2'd0,
    CMD_LEFT  = 2'd1,
    CMD_FWD   = 2'd2
  } cmd_e;

  // body: R, sub, F, L, sub, F, sub, L, F, sub, R
  localparam logic [POS_W-1:0] POS_R_FIRST = 4'd0;
  localparam logic [POS_W-1:0] POS_SUB_A   = 4'd1;
  localparam logic [POS_W-1:0] POS_L_A     = 4'd3;
  localparam logic [POS_W-1:0] POS_SUB_B   = 4'd4;
  localparam logic [POS_W-1:0] POS_SUB_C   = 4'd6;
  localparam logic [POS_W-1:0] POS_L_B     = 4'd7;
  localparam logic [POS_W-1:0] POS_SUB_D   = 4'd9;
  localparam logic [POS_W-1:0] POS_R_LAST  = 4'd10;
  localparam logic [POS_W-1:0] BODY_END    = 4'd11;

  typedef struct packed {
    logic             neg;
    logic [POS_W-1:0] pos;
  } frame_t;

  typedef struct packed {
    logic init;   // start a new curve
    logic step;   // advance the frame walk by one step
  } dp_cmd_t;

  typedef struct packed {
    logic running;   // a curve is in progress
    logic emit;      // current step produces a command
    logic finish;    // current step ends the request
    logic out_busy;  // output register cannot take a new command
  } dp_status_t;

endpackage

`default_nettype wire

FILE: design/htcg_if.sv
// ----------------------------------------------------------------------------
// htcg channel interfaces
// Valid/ready channels for requests, commands and the order register.
// ----------------------------------------------------------------------------
`default_nettype none

interface htcg_req_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface htcg_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic       angle_negative;
  logic       last;

  modport source (output valid, output command, output angle_negative, output last,
                  input ready);
  modport sink   (input valid, input command, input angle_negative, input last,
                  output ready);
endinterface

interface htcg_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] curve_order;

  modport source (output valid, output curve_order, input ready);
  modport sink   (input valid, input curve_order, output ready);
endinterface

`default_nettype wire

FILE: design/htcg_datapath.sv
// ----------------------------------------------------------------------------
// htcg_datapath
// Frame stack, top frame, order register and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module htcg_datapath (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire htcg_pkg::dp_cmd_t                cmd_i,
  output htcg_pkg::dp_status_t                  status_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [htcg_pkg::ORDER_W-1:0]     cfg_order_i,
  input  wire logic                             out_ready_i,
  output logic                                  out_valid_o,
  output logic [1:0]                            out_command_o,
  output logic                                  out_angle_neg_o,
  output logic                                  out_last_o
);

  localparam int unsigned LVL_W = htcg_pkg::LVL_W;
  localparam int unsigned IDX_W = htcg_pkg::IDX_W;
  localparam int unsigned ORD_W = htcg_pkg::ORDER_W;

  // frames below the top one; top frame lives in top_q
  htcg_pkg::frame_t stack_q [htcg_pkg::MAX_ORDER];
  htcg_pkg::frame_t top_q;

  logic [LVL_W-1:0] level_q;
  logic             running_q;
  logic [ORD_W-1:0] order_q;
  logic             out_valid_q;
  htcg_pkg::cmd_e   out_cmd_q;
  logic             out_neg_q;
  logic             out_last_q;

  logic [ORD_W-1:0] eff_order;
  logic [LVL_W-1:0] lvl_m1, lvl_m2;
  logic [htcg_pkg::POS_W-1:0] pos, pos_inc;
  logic             lvl_zero, is_pop, is_sub, emit, push_ok, is_last, flip;
  htcg_pkg::cmd_e   cmd;

  always_comb begin
    if (order_q == '0) begin
      eff_order = ORD_W'(1);
    end else if (order_q > ORD_W'(htcg_pkg::MAX_ORDER)) begin
      eff_order = ORD_W'(htcg_pkg::MAX_ORDER);
    end else begin
      eff_order = order_q;
    end
  end

  assign pos      = top_q.pos;
  assign pos_inc  = pos + htcg_pkg::POS_W'(1);
  assign lvl_m1   = level_q - LVL_W'(1);
  assign lvl_m2   = level_q - LVL_W'(2);
  assign lvl_zero = (level_q == '0);
  assign is_pop   = (pos >= htcg_pkg::BODY_END);
  assign is_sub   = (pos == htcg_pkg::POS_SUB_A) || (pos == htcg_pkg::POS_SUB_B) ||
                    (pos == htcg_pkg::POS_SUB_C) || (pos == htcg_pkg::POS_SUB_D);
  assign flip     = (pos == htcg_pkg::POS_SUB_A) || (pos == htcg_pkg::POS_SUB_D);
  assign emit     = !lvl_zero && !is_pop && !is_sub;
  // eff_order never exceeds MAX_ORDER, so it fits the level width
  assign push_ok  = (level_q < LVL_W'(eff_order));
  assign is_last  = (pos == htcg_pkg::POS_R_LAST) && (level_q == LVL_W'(1));

  always_comb begin
    if ((pos == htcg_pkg::POS_R_FIRST) || (pos == htcg_pkg::POS_R_LAST)) begin
      cmd = htcg_pkg::CMD_RIGHT;
    end else if ((pos == htcg_pkg::POS_L_A) || (pos == htcg_pkg::POS_L_B)) begin
      cmd = htcg_pkg::CMD_LEFT;
    end else begin
      cmd = htcg_pkg::CMD_FWD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q     <= '0;
      running_q   <= 1'b0;
      order_q     <= ORD_W'(1);
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        order_q <= cfg_order_i;
      end
      if (cmd_i.step && emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.init) begin
        level_q   <= LVL_W'(1);
        running_q <= 1'b1;
      end else if (cmd_i.step) begin
        priority if (lvl_zero) begin
          running_q <= 1'b0;
        end else if (is_pop) begin
          level_q <= lvl_m1;
        end else if (is_sub) begin
          if (push_ok) begin
            level_q <= level_q + LVL_W'(1);
          end
        end else if (is_last) begin
          level_q   <= '0;
          running_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.init) begin
      top_q <= '0;
    end else if (cmd_i.step && !lvl_zero) begin
      if (is_pop) begin
        top_q <= stack_q[lvl_m2[IDX_W-1:0]];
      end else if (is_sub && push_ok) begin
        stack_q[lvl_m1[IDX_W-1:0]] <= '{neg: top_q.neg, pos: pos_inc};
        top_q <= '{neg: top_q.neg ^ flip, pos: '0};
      end else begin
        top_q.pos <= pos_inc;
      end
    end
    if (cmd_i.step && emit) begin
      out_cmd_q  <= cmd;
      out_neg_q  <= (cmd == htcg_pkg::CMD_FWD) ? 1'b0 : top_q.neg;
      out_last_q <= is_last;
    end
  end

  assign status_o.running  = running_q;
  assign status_o.emit     = emit;
  assign status_o.finish   = lvl_zero || emit;
  assign status_o.out_busy = out_valid_q && !out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign out_command_o   = out_cmd_q;
  assign out_angle_neg_o = out_neg_q;
  assign out_last_o      = out_last_q;

endmodule

`default_nettype wire

FILE: design/htcg_ctrl.sv
// ----------------------------------------------------------------------------
// htcg_ctrl
// Request sequencer: takes a request, then steps the frame walk until a
// command is produced or the curve runs out.
// ----------------------------------------------------------------------------
`default_nettype none

module htcg_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 req_valid_i,
  input  wire logic                 req_restart_i,
  output logic                      req_ready_o,
  input  wire htcg_pkg::dp_status_t status_i,
  output htcg_pkg::dp_cmd_t         cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign req_ready_o = (state_q == ST_IDLE);
  assign accept      = req_valid_i && req_ready_o;

  always_comb begin
    cmd_o.init = accept && req_restart_i;
    // hold off a command step while the output register is still full
    cmd_o.step = (state_q == ST_RUN) && !(status_i.emit && status_i.out_busy);
    state_d    = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (req_restart_i || status_i.running)) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (cmd_o.step && status_i.finish) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

FILE: design/hilbert_turtle_command_generator_unit.sv
// ----------------------------------------------------------------------------
// hilbert_turtle_command_generator_unit
// Turtle command stream of a Hilbert curve, at most one command per request.
// ----------------------------------------------------------------------------
// Each request returns the next command of the curve (right turn, left turn
// or forward), or, when restart is set, starts a new curve and returns its
// first command. No new request is taken until the current one is done. The
// frame walk then steps on: the command is read from the top frame's current
// position, or the walk first has to pop a finished frame, push a new one or
// skip a sub-curve at the deepest level. A step that would produce a command
// is held for as long as the previous command still waits unclaimed in the
// output register. The order register (used clamped to 1..8) is to be written
// through the configuration channel only while no request is pending; the
// block itself does not enforce this. After the last command, plain requests
// return nothing until a restart. A finished command waits in the output
// register while the next request is already taken.
`default_nettype none

`include "hilbert_turtle_command_generator_unit_macros.svh"

module hilbert_turtle_command_generator_unit (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  htcg_req_if.sink   req_i,
  htcg_cmd_if.source cmd_o,
  htcg_cfg_if.sink   cfg_i
);

  htcg_pkg::dp_cmd_t    dp_cmd;
  htcg_pkg::dp_status_t dp_status;

  assign cfg_i.ready = 1'b1;

  htcg_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (req_i.valid),
    .req_restart_i (req_i.restart),
    .req_ready_o   (req_i.ready),
    .status_i      (dp_status),
    .cmd_o         (dp_cmd)
  );

  htcg_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (dp_cmd),
    .status_o        (dp_status),
    .cfg_we_i        (cfg_i.valid && cfg_i.ready),
    .cfg_order_i     (cfg_i.curve_order),
    .out_ready_i     (cmd_o.ready),
    .out_valid_o     (cmd_o.valid),
    .out_command_o   (cmd_o.command),
    .out_angle_neg_o (cmd_o.angle_negative),
    .out_last_o      (cmd_o.last)
  );

  `HTCG_ASSERT_NEXT(a_restart_runs, req_i.valid && req_i.ready && req_i.restart, dp_status.running && !req_i.ready, "restart did not start a curve")
  `HTCG_ASSERT_SAME(a_emit_running, dp_cmd.step && dp_status.emit, dp_status.running, "command produced with no curve running")
  `HTCG_ASSERT_SAME(a_no_overwrite, cmd_o.valid && !cmd_o.ready && dp_cmd.step, !dp_status.emit, "pending command overwritten")

endmodule

`default_nettype wire

FILE: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top - Hilbert turtle command generator testbench
// Drives requests and order writes, predicts each turtle command from a
// frame-stack walk of its own, and checks every command field by field.
// ----------------------------------------------------------------------------

module tb_top;

  localparam int unsigned ITEMS        = 1000;
  localparam int unsigned QUIET_FROM   = ITEMS - 100;
  localparam int unsigned DRAIN_CYCLES = 2 * htcg_pkg::MAX_ORDER + 8;
  localparam int unsigned HOLD_AFTER   = 300;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned PLAN_ROWS    = 25;

  typedef struct packed {
    htcg_pkg::cmd_e command;
    logic           neg;
    logic           last;
  } turtle_cmd_t;

  typedef struct {
    logic [3:0]  order;
    bit          restart;
    bit          typed;
    bit          yields;
    turtle_cmd_t want;
  } plan_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  htcg_req_if req_if ();
  htcg_cmd_if cmd_if ();
  htcg_cfg_if cfg_if ();

  hilbert_turtle_command_generator_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .cmd_o  (cmd_if),
    .cfg_i  (cfg_if)
  );

  // predictor state
  htcg_pkg::frame_t frames [htcg_pkg::MAX_ORDER];
  int unsigned depth = 0;
  bit          busy = 1'b0;
  logic [3:0]  ord_reg = 4'd1;

  turtle_cmd_t pending_cmds [$];
  int unsigned made = 0;
  int unsigned cmds_seen = 0;
  int unsigned errors = 0;
  int unsigned gap_pct = 20;
  bit          quiet = 1'b0;
  bit          long_hold_done = 1'b0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Walks the frame stack to the next command; 0 when the request yields none.
  function automatic bit next_turtle_command(input bit restart, output turtle_cmd_t c);
    int unsigned      ord;
    int unsigned      top;
    htcg_pkg::frame_t f;
    ord = (ord_reg == 4'd0) ? 1 :
          ((ord_reg > htcg_pkg::MAX_ORDER) ? htcg_pkg::MAX_ORDER : ord_reg);
    c = '{htcg_pkg::CMD_RIGHT, 1'b0, 1'b0};
    if (restart) begin
      frames[0] = '0;
      depth = 1;
      busy = 1'b1;
    end
    if (!busy) return 1'b0;
    while (depth > 0 && depth <= htcg_pkg::MAX_ORDER) begin
      top = depth - 1;
      f = frames[top];
      if (f.pos >= htcg_pkg::BODY_END) begin
        depth--;
        continue;
      end
      frames[top].pos = f.pos + 4'd1;
      if (f.pos inside {htcg_pkg::POS_SUB_A, htcg_pkg::POS_SUB_B,
                        htcg_pkg::POS_SUB_C, htcg_pkg::POS_SUB_D}) begin
        // outer sub-curves flip the sign, inner two keep it; none at the deepest level
        if (depth < ord) begin
          frames[depth] = '{neg: f.neg ^ ((f.pos == htcg_pkg::POS_SUB_A) ||
                                          (f.pos == htcg_pkg::POS_SUB_D)),
                            pos: htcg_pkg::POS_R_FIRST};
          depth++;
        end
        continue;
      end
      if (f.pos == htcg_pkg::POS_R_FIRST || f.pos == htcg_pkg::POS_R_LAST)
        c.command = htcg_pkg::CMD_RIGHT;
      else if (f.pos == htcg_pkg::POS_L_A || f.pos == htcg_pkg::POS_L_B)
        c.command = htcg_pkg::CMD_LEFT;
      else c.command = htcg_pkg::CMD_FWD;
      c.neg = (c.command == htcg_pkg::CMD_FWD) ? 1'b0 : f.neg;
      if (f.pos == htcg_pkg::POS_R_LAST && depth == 1) begin
        c.last = 1'b1;
        depth = 0;
        busy = 1'b0;
      end
      return 1'b1;
    end
    depth = 0;
    busy = 1'b0;
    return 1'b0;
  endfunction

  function automatic plan_row_t row_known(logic [3:0] ord, bit rs, htcg_pkg::cmd_e cmd,
                                          bit neg, bit last);
    plan_row_t r;
    r = '{ord, rs, 1'b1, 1'b1, '{cmd, neg, last}};
    return r;
  endfunction

  function automatic plan_row_t row_silent(logic [3:0] ord, bit rs);
    plan_row_t r;
    r = '{ord, rs, 1'b1, 1'b0, '{htcg_pkg::CMD_RIGHT, 1'b0, 1'b0}};
    return r;
  endfunction

  function automatic plan_row_t row_open(logic [3:0] ord, bit rs);
    plan_row_t r;
    r = '{ord, rs, 1'b0, 1'b0, '{htcg_pkg::CMD_RIGHT, 1'b0, 1'b0}};
    return r;
  endfunction

  // Lower the request line, let every command arrive, then let the walk settle.
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_order(input logic [3:0] value);
    wait_drained();
    cfg_if.valid <= 1'b1;
    cfg_if.curve_order <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    ord_reg = value;
  endtask

  task automatic issue_request(input bit restart, input bit typed = 1'b0,
                               input bit yields = 1'b0,
                               input turtle_cmd_t want = '0);
    turtle_cmd_t got;
    bit          has;
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.restart <= restart;
    do @(posedge clk_i); while (!req_if.ready);
    has = next_turtle_command(restart, got);
    if (typed) begin
      has = yields;
      got = want;
    end
    if (has) begin
      pending_cmds.push_back(got);
      made++;
      if (made >= QUIET_FROM) quiet = 1'b1;
    end
  endtask

  // command sink: random ready bursts plus one long hold-off
  initial begin : cmd_drain
    cmd_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!long_hold_done && cmds_seen >= HOLD_AFTER && req_if.valid) begin
        long_hold_done = 1'b1;
        cmd_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (!quiet && $urandom_range(0, 99) < 20) begin
        cmd_if.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end else begin
        cmd_if.ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    turtle_cmd_t want;
    if (rst_ni && cmd_if.valid && cmd_if.ready) begin
      cmds_seen++;
      if (pending_cmds.size() == 0) begin
        $error("unexpected command %0d", cmd_if.command);
        errors++;
      end else begin
        want = pending_cmds.pop_front();
        if (cmd_if.command !== want.command) begin
          $error("command: expected %0d, got %0d", want.command, cmd_if.command);
          errors++;
        end
        if (cmd_if.angle_negative !== want.neg) begin
          $error("angle_negative: expected %0d, got %0d", want.neg, cmd_if.angle_negative);
          errors++;
        end
        if (cmd_if.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, cmd_if.last);
          errors++;
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned stalled;
    stalled = 0;
    while (stalled < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (req_if.valid && req_if.ready) || (cmd_if.valid && cmd_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        stalled = 0;
      else
        stalled++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    plan_row_t   plan [PLAN_ROWS];
    int unsigned pick;
    int unsigned run_len;
    logic [3:0]  next_ord;

    req_if.valid <= 1'b0;
    req_if.restart <= 1'b0;
    cfg_if.valid <= 1'b0;
    cfg_if.curve_order <= 4'd0;

    plan = '{
      row_silent(4'd1, 1'b0),                       // request before any curve
      row_known(4'd1, 1'b1, htcg_pkg::CMD_RIGHT, 1'b0, 1'b0),
      row_known(4'd1, 1'b0, htcg_pkg::CMD_FWD, 1'b0, 1'b0),
      row_known(4'd1, 1'b0, htcg_pkg::CMD_LEFT, 1'b0, 1'b0),
      row_known(4'd1, 1'b0, htcg_pkg::CMD_FWD, 1'b0, 1'b0),
      row_known(4'd1, 1'b0, htcg_pkg::CMD_LEFT, 1'b0, 1'b0),
      row_known(4'd1, 1'b0, htcg_pkg::CMD_FWD, 1'b0, 1'b0),
      row_known(4'd1, 1'b0, htcg_pkg::CMD_RIGHT, 1'b0, 1'b1),
      row_silent(4'd1, 1'b0),                       // request after the last command
      row_known(4'd0, 1'b1, htcg_pkg::CMD_RIGHT, 1'b0, 1'b0), // order 0 runs as 1
      row_known(4'd0, 1'b0, htcg_pkg::CMD_FWD, 1'b0, 1'b0),
      row_known(4'd0, 1'b1, htcg_pkg::CMD_RIGHT, 1'b0, 1'b0), // restart mid-curve
      row_known(4'd15, 1'b1, htcg_pkg::CMD_RIGHT, 1'b0, 1'b0),// saturates to max order
      row_open(4'd15, 1'b0),
      row_open(4'd15, 1'b0),
      row_open(4'd15, 1'b0),
      row_open(4'd15, 1'b0),
      row_open(4'd2, 1'b0),                         // order drops below stack depth
      row_open(4'd2, 1'b0),
      row_open(4'd2, 1'b0),
      row_open(4'd2, 1'b0),
      row_known(4'd8, 1'b1, htcg_pkg::CMD_RIGHT, 1'b0, 1'b0),
      row_open(4'd8, 1'b0),
      row_open(4'd8, 1'b0),
      row_open(4'd8, 1'b0)
    };

    @(posedge rst_ni);
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].order != ord_reg) write_order(plan[i].order);
      issue_request(plan[i].restart, plan[i].typed, plan[i].yields, plan[i].want);
    end

    while (made < ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) next_ord = 4'd0;
      else if (pick < 20) next_ord = $urandom_range(9, 15);
      else if (pick < 25) next_ord = $urandom_range(6, 8);
      else if (pick < 35) next_ord = $urandom_range(4, 5);
      else next_ord = $urandom_range(1, 3);
      if ($urandom_range(0, 3) != 0) write_order(next_ord);
      gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
      // now and then keep the running curve, so a new order lands mid-curve
      if ($urandom_range(0, 99) >= 15) issue_request(1'b1);
      run_len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 30) : 150;
      for (int k = 0; k < run_len && busy; k++)
        issue_request($urandom_range(0, 99) < 2);
      repeat ($urandom_range(0, 2)) issue_request(1'b0);
    end

    req_if.valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
